/* src/dogx_pkg.sv */
`timescale 1ns / 1ps

package dogx_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned TripleW = 3 * PixW;
  localparam int unsigned RowOutW = 12;
  localparam int unsigned ColOutW = 10;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 4096;

  // configuration port
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;

  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd480;

  // one raster position of all three layers: {above, mid, below}
  typedef logic [TripleW-1:0] triple_t;

  // one window column, three consecutive rows, top is the oldest
  typedef struct packed {
    triple_t top;
    triple_t mid;
    triple_t bot;
  } column_t;

  // which centers an input completes, and which window edges lie in the frame
  typedef struct packed {
    logic [3:0] cand;    // (i-1,j-1), (i-1,j), (i,j-1), (i,j)
    logic       row_ge1;
    logic       row_ge2;
    logic       col_ge1;
    logic       col_ge2;
  } plan_t;

endpackage

/* src/dogx_if.sv */
`timescale 1ns / 1ps

interface dogx_pix_if import dogx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] below_pixel;
  logic [PixW-1:0] mid_pixel;
  logic [PixW-1:0] above_pixel;

  modport source (output valid, output below_pixel, output mid_pixel, output above_pixel,
                  input ready);
  modport sink   (input valid, input below_pixel, input mid_pixel, input above_pixel,
                  output ready);
endinterface

interface dogx_res_if import dogx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RowOutW-1:0] center_row;
  logic [ColOutW-1:0] center_col;
  logic [PixW-1:0]    center_value;
  logic               is_extremum;
  logic               last_of_run;

  modport source (output valid, output center_row, output center_col, output center_value,
                  output is_extremum, output last_of_run, input ready);
  modport sink   (input valid, input center_row, input center_col, input center_value,
                  input is_extremum, input last_of_run, output ready);
endinterface

/* src/dogx_ram.sv */
`timescale 1ns / 1ps

module dogx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first; rdata holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dogx_line_fetch.sv */
`timescale 1ns / 1ps

module dogx_line_fetch import dogx_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  parameter int unsigned ColW      = $clog2(MaxWidth),
  parameter int unsigned RowW      = $clog2(MaxHeight)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [ColW-1:0] w_last_i,
  input  logic [RowW-1:0] h_last_i,
  dogx_pix_if.sink        pix_i,
  input  logic            col_take_i,
  output logic            col_valid_o,
  output column_t         column_o,
  output plan_t           plan_o,
  output logic [RowW-1:0] row_o,
  output logic [ColW-1:0] col_o
);

  localparam int unsigned WordW = 2 * TripleW;

  logic            accept;
  logic            b_adv;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            b_valid_q, b_valid_d;
  logic [RowW-1:0] b_row_q;
  logic [ColW-1:0] b_col_q;
  triple_t         b_pix_q;
  logic            use_fwd_q, use_fwd_d;
  logic [WordW-1:0] fwd_q;
  logic [WordW-1:0] ram_rdata;
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] wr_word;
  logic            ram_re;
  triple_t         recent;
  triple_t         older;

  assign pix_i.ready = !b_valid_q || col_take_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign b_adv       = b_valid_q && col_take_i;
  assign ram_re      = accept;

  // raster position of the next request
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_q == w_last_i) begin
        col_d = '0;
        row_d = (row_q == h_last_i) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // each line word keeps the two previous rows at a column: {row i-2, row i-1}
  dogx_ram #(
    .Width (WordW),
    .Depth (MaxWidth),
    .AddrW (ColW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_col_q),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign rd_word = use_fwd_q ? fwd_q : ram_rdata;
  assign recent  = rd_word[TripleW-1:0];
  assign older   = rd_word[WordW-1:TripleW];
  assign wr_word = {recent, b_pix_q};

  // a one-column frame reads the entry being written back in the same cycle
  assign use_fwd_d = b_adv && (b_col_q == col_q);
  assign b_valid_d = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      use_fwd_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (accept) begin
        use_fwd_q <= use_fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_row_q <= row_q;
      b_col_q <= col_q;
      b_pix_q <= {pix_i.above_pixel, pix_i.mid_pixel, pix_i.below_pixel};
      fwd_q   <= wr_word;
    end
  end

  always_comb begin
    logic row_last;
    logic col_last;
    row_last       = (b_row_q == h_last_i);
    col_last       = (b_col_q == w_last_i);
    plan_o.row_ge1 = (b_row_q != '0);
    plan_o.row_ge2 = (b_row_q > RowW'(1));
    plan_o.col_ge1 = (b_col_q != '0);
    plan_o.col_ge2 = (b_col_q > ColW'(1));
    plan_o.cand[0] = plan_o.row_ge1 && plan_o.col_ge1;
    plan_o.cand[1] = plan_o.row_ge1 && col_last;
    plan_o.cand[2] = row_last && plan_o.col_ge1;
    plan_o.cand[3] = row_last && col_last;
  end

  assign col_valid_o  = b_valid_q;
  assign column_o.top = older;
  assign column_o.mid = recent;
  assign column_o.bot = b_pix_q;
  assign row_o        = b_row_q;
  assign col_o        = b_col_q;

  a_no_read_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !col_take_i |-> !ram_re)
    else $error("line store read issued while the fetch stage is stalled");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !col_take_i |=> b_valid_q && $stable(b_col_q) && $stable(b_row_q))
    else $error("stalled fetch stage lost its position");

endmodule

/* src/dogx_judge.sv */
`timescale 1ns / 1ps

module dogx_judge import dogx_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  parameter int unsigned ColW      = $clog2(MaxWidth),
  parameter int unsigned RowW      = $clog2(MaxHeight)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            col_valid_i,
  input  column_t         column_i,
  input  plan_t           plan_i,
  input  logic [RowW-1:0] row_i,
  input  logic [ColW-1:0] col_i,
  output logic            col_take_o,
  dogx_res_if.source      res_o
);

  column_t         win_q [3];   // index 0 is the oldest column
  logic [3:0]      c_pend_q;
  plan_t           c_plan_q;
  logic [RowW-1:0] c_row_q;
  logic [ColW-1:0] c_col_q;

  logic               o_valid_q;
  logic [RowOutW-1:0] o_row_q;
  logic [ColOutW-1:0] o_col_q;
  logic [PixW-1:0]    o_value_q;
  logic               o_ext_q;
  logic               o_last_q;

  logic            c_busy;
  logic            o_free;
  logic            c_emit;
  logic            c_last;
  logic            c_load;
  logic [3:0]      pick;
  logic            sel_low_row;
  logic            sel_right;
  column_t         col_l, col_m, col_r;
  logic [2:0]      vr, vc;
  triple_t         ctr_triple;
  logic [PixW-1:0] ctr;
  logic            gt_any, lt_any;
  logic            is_ext;
  logic [RowW-1:0] res_row;
  logic [ColW-1:0] res_col;

  function automatic triple_t pick_row(column_t cl, logic low, logic [1:0] r);
    triple_t t;
    if (low) begin
      t = (r == 2'd0) ? cl.mid : cl.bot;
    end else if (r == 2'd0) begin
      t = cl.top;
    end else if (r == 2'd1) begin
      t = cl.mid;
    end else begin
      t = cl.bot;
    end
    return t;
  endfunction

  assign c_busy     = |c_pend_q;
  assign o_free     = !o_valid_q || res_o.ready;
  assign c_emit     = c_busy && o_free;
  assign pick       = c_pend_q & (~c_pend_q + 4'd1);
  assign c_last     = ((c_pend_q & ~pick) == 4'd0);
  assign col_take_o = !c_busy || (c_emit && c_last);
  assign c_load     = col_valid_i && col_take_o;

  // lower two candidates are centered on the current row, odd ones on the current column
  assign sel_low_row = pick[2] || pick[3];
  assign sel_right   = pick[1] || pick[3];

  always_comb begin
    if (sel_right) begin
      col_l = win_q[1];
      col_m = win_q[2];
      col_r = win_q[2];
      vc    = {1'b0, 1'b1, c_plan_q.col_ge1};
    end else begin
      col_l = win_q[0];
      col_m = win_q[1];
      col_r = win_q[2];
      vc    = {1'b1, 1'b1, c_plan_q.col_ge2};
    end
    if (sel_low_row) begin
      vr = {1'b0, 1'b1, c_plan_q.row_ge1};
    end else begin
      vr = {1'b1, 1'b1, c_plan_q.row_ge2};
    end
  end

  assign ctr_triple = pick_row(col_m, sel_low_row, 2'd1);
  assign ctr        = ctr_triple[2*PixW-1:PixW];

  always_comb begin : p_judge
    triple_t         nbr;
    logic [PixW-1:0] u;
    gt_any = 1'b0;
    lt_any = 1'b0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        unique case (c)
          0:       nbr = pick_row(col_l, sel_low_row, 2'(r));
          1:       nbr = pick_row(col_m, sel_low_row, 2'(r));
          default: nbr = pick_row(col_r, sel_low_row, 2'(r));
        endcase
        for (int l = 0; l < 3; l++) begin
          u = nbr[l*PixW +: PixW];
          if (!(r == 1 && c == 1 && l == 1) && vr[r] && vc[c]) begin
            if (ctr > u) gt_any = 1'b1;
            if (ctr < u) lt_any = 1'b1;
          end
        end
      end
    end
  end

  // flat windows and mixed windows are both rejected
  assign is_ext  = (gt_any || lt_any) && !(gt_any && lt_any);
  assign res_row = sel_low_row ? c_row_q : c_row_q - RowW'(1);
  assign res_col = sel_right ? c_col_q : c_col_q - ColW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k] <= '0;
      end
      c_pend_q  <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (c_load) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= column_i;
        c_pend_q <= plan_i.cand;
      end else if (c_emit) begin
        c_pend_q <= c_pend_q & ~pick;
      end
      if (c_emit) begin
        o_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_plan_q <= plan_i;
      c_row_q  <= row_i;
      c_col_q  <= col_i;
    end
    if (c_emit) begin
      o_row_q   <= RowOutW'(res_row);
      o_col_q   <= ColOutW'(res_col);
      o_value_q <= ctr;
      o_ext_q   <= is_ext;
      o_last_q  <= c_last;
    end
  end

  assign res_o.valid        = o_valid_q;
  assign res_o.center_row   = o_row_q;
  assign res_o.center_col   = o_col_q;
  assign res_o.center_value = o_value_q;
  assign res_o.is_extremum  = o_ext_q;
  assign res_o.last_of_run  = o_last_q;

  a_pend_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_busy && !c_load |=> (c_pend_q & ~$past(c_pend_q)) == 4'd0)
    else $error("pending centers grew without a new column");

  a_run_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !o_last_q |-> c_busy)
    else $error("non-final result shown with no centers left in the run");

endmodule

/* src/dog_extremum_detector_core.sv */
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// pix_i    in   valid/ready        below_pixel, mid_pixel, above_pixel (8 bits each)
// res_o    out  valid/ready        center_row, center_col, center_value, is_extremum,
//                                  last_of_run
// cfg      in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
// A request is taken every cycle while res_o is ready and each one completes at most one
// center; one that completes n centers (two at a row end, up to four in the last row) holds
// pix_i while the single judge unit issues them, once per cycle while res_o is ready.
// A request's first result goes through the fetch, center and output registers to res_o.
// Reset: position row 0 / column 0, frame 640 x 480; the line store is not cleared,
// rows and columns outside the current frame are masked in the judge.
// A stalled res_o holds its result while the next window column is already prepared.

module dog_extremum_detector_core import dogx_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  dogx_pix_if.sink            pix_i,
  dogx_res_if.source          res_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);

  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic                    restart;
  logic [ColW-1:0]         w_last;
  logic [RowW-1:0]         h_last;

  logic            col_valid;
  logic            col_take;
  column_t         column;
  plan_t           plan;
  logic [RowW-1:0] col_row;
  logic [ColW-1:0] col_col;

  assign restart = cfg_we_i && ((cfg_idx_i == CfgFrameWidth) || (cfg_idx_i == CfgFrameHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFrameWidth) begin
        frame_width_q <= cfg_wdata_i[FrameWidthW-1:0];
      end
      if (cfg_idx_i == CfgFrameHeight) begin
        frame_height_q <= cfg_wdata_i[FrameHeightW-1:0];
      end
    end
  end

  // last column and row index, sizes clamped to 1..max
  always_comb begin
    if (frame_width_q == '0) begin
      w_last = '0;
    end else if (32'(frame_width_q) >= MaxWidth) begin
      w_last = ColW'(MaxWidth - 1);
    end else begin
      w_last = ColW'(32'(frame_width_q) - 32'd1);
    end
    if (frame_height_q == '0) begin
      h_last = '0;
    end else if (32'(frame_height_q) >= MaxHeight) begin
      h_last = RowW'(MaxHeight - 1);
    end else begin
      h_last = RowW'(32'(frame_height_q) - 32'd1);
    end
  end

  dogx_line_fetch #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .ColW      (ColW),
    .RowW      (RowW)
  ) u_fetch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .w_last_i    (w_last),
    .h_last_i    (h_last),
    .pix_i       (pix_i),
    .col_take_i  (col_take),
    .col_valid_o (col_valid),
    .column_o    (column),
    .plan_o      (plan),
    .row_o       (col_row),
    .col_o       (col_col)
  );

  dogx_judge #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .ColW      (ColW),
    .RowW      (RowW)
  ) u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (col_valid),
    .column_i    (column),
    .plan_i      (plan),
    .row_i       (col_row),
    .col_i       (col_col),
    .col_take_o  (col_take),
    .res_o       (res_o)
  );

endmodule

/* sim/dogx_center_checker.sv */
`timescale 1ns / 1ps

module dogx_center_checker import dogx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  dogx_pix_if                 pix_i,
  dogx_res_if                 res_i,
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  centers_o,
  output int                  peaks_o
);

  localparam int unsigned MaxPrinted = 50;

  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [PixW-1:0]    value;
    logic               peak;
    logic               last;
  } center_t;

  // three most recent rows of {above, mid, below}, indexed by row mod 3
  bit [TripleW-1:0]        layer_rows [3][MaxWidthDef];
  logic [FrameWidthW-1:0]  frame_w;
  logic [FrameHeightW-1:0] frame_h;
  int unsigned             row_pos;
  int unsigned             col_pos;
  center_t                 centers_q [$];
  int                      n_mismatch;
  int                      n_centers;
  int                      n_peaks;

  assign mismatches_o = n_mismatch;
  assign centers_o    = n_centers;
  assign peaks_o      = n_peaks;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PixW-1:0] pix_at(int unsigned r, int unsigned c, int unsigned l);
    return layer_rows[r % 3][c % MaxWidthDef][l*PixW +: PixW];
  endfunction

  // ties allowed, nothing strictly on the other side, at least one strict difference
  function automatic bit is_peak(int unsigned r, int unsigned c, int unsigned w,
                                 int unsigned h);
    logic [PixW-1:0] v;
    logic [PixW-1:0] u;
    int              side;
    int              rr;
    int              cc;
    v    = pix_at(r, c, 1);
    side = 0;
    for (int l = 0; l < 3; l++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = int'(r) + dr;
          cc = int'(c) + dc;
          if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
          if (l == 1 && dr == 0 && dc == 0) continue;
          u = pix_at(rr, cc, l);
          if (v > u) begin
            if (side < 0) return 1'b0;
            side = 1;
          end else if (v < u) begin
            if (side > 0) return 1'b0;
            side = -1;
          end
        end
      end
    end
    return side != 0;
  endfunction

  // store the request and queue every center whose clipped window it completes
  function automatic void predict_centers(logic [TripleW-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned i;
    int unsigned j;
    int unsigned rows [2];
    int unsigned cols [2];
    int unsigned nr;
    int unsigned nc;
    center_t     ctr;
    w = clamp_size(frame_w, MaxWidthDef);
    h = clamp_size(frame_h, MaxHeightDef);
    if (row_pos >= h || col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
    end
    i  = row_pos;
    j  = col_pos;
    nr = 0;
    nc = 0;
    layer_rows[i % 3][j % MaxWidthDef] = px;
    if (i >= 1) rows[nr++] = i - 1;
    if (i == h - 1) rows[nr++] = i;
    if (j >= 1) cols[nc++] = j - 1;
    if (j == w - 1) cols[nc++] = j;
    for (int a = 0; a < nr; a++) begin
      for (int b = 0; b < nc; b++) begin
        ctr.row   = RowOutW'(rows[a]);
        ctr.col   = ColOutW'(cols[b]);
        ctr.value = pix_at(rows[a], cols[b], 1);
        ctr.peak  = is_peak(rows[a], cols[b], w, h);
        ctr.last  = (a == nr - 1) && (b == nc - 1);
        centers_q = {centers_q, ctr};
      end
    end
    if (j + 1 >= w) begin
      col_pos = 0;
      row_pos = (i + 1 >= h) ? 0 : i + 1;
    end else begin
      col_pos = j + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_mismatch < MaxPrinted) $display("%0t ns: mismatch, %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input center_t at);
    if (got !== want) begin
      report_mismatch($sformatf("%s of center (%0d,%0d): got %0d, expected %0d",
                                name, at.row, at.col, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    center_t want;
    if (!rst_ni) begin
      frame_w = FrameWidthRst;
      frame_h = FrameHeightRst;
      row_pos = 0;
      col_pos = 0;
      centers_q.delete();
      outstanding_o <= 0;
    end else begin
      // only the two listed registers restart the frame
      if (cfg_we_i && cfg_idx_i == CfgFrameWidth) begin
        frame_w = cfg_wdata_i[FrameWidthW-1:0];
        row_pos = 0;
        col_pos = 0;
      end else if (cfg_we_i && cfg_idx_i == CfgFrameHeight) begin
        frame_h = cfg_wdata_i[FrameHeightW-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      if (pix_i.valid && pix_i.ready) begin
        predict_centers({pix_i.above_pixel, pix_i.mid_pixel, pix_i.below_pixel});
      end
      if (res_i.valid && res_i.ready) begin
        if (centers_q.size() == 0) begin
          report_mismatch($sformatf("result for (%0d,%0d) with nothing expected",
                                    res_i.center_row, res_i.center_col));
        end else begin
          want = centers_q.pop_front();
          n_centers++;
          if (want.peak) n_peaks++;
          check_field("center_row", 32'(res_i.center_row), 32'(want.row), want);
          check_field("center_col", 32'(res_i.center_col), 32'(want.col), want);
          check_field("center_value", 32'(res_i.center_value), 32'(want.value), want);
          check_field("is_extremum", 32'(res_i.is_extremum), 32'(want.peak), want);
          check_field("last_of_run", 32'(res_i.last_of_run), 32'(want.last), want);
        end
      end
      outstanding_o <= centers_q.size();
    end
  end

endmodule

/* sim/dog_extremum_detector_core_tb.sv */
`timescale 1ns / 1ps

module dog_extremum_detector_core_tb;
  import dogx_pkg::*;

  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;

  // indexes past the register list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  typedef enum logic [1:0] {PixRandom, PixTwoLevel, PixFlat, PixRails} pix_mode_e;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int        mismatches;
  int        outstanding;
  int        centers;
  int        peaks;
  int        n_requests;
  int        n_settings;
  bit        tx_gaps = 1'b1;
  bit        rx_stalls = 1'b1;
  bit        hold_off_req = 1'b0;
  pix_mode_e pix_mode = PixRandom;
  logic [PixW-1:0] level_lo;
  logic [PixW-1:0] level_hi;
  logic [PixW-1:0] level_flat;

  dogx_pix_if pix_if ();
  dogx_res_if res_if ();

  dog_extremum_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  dogx_center_checker u_center_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pix_i         (pix_if),
    .res_i         (res_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .centers_o     (centers),
    .peaks_o       (peaks)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic triple_t make_pixel();
    triple_t px;
    for (int l = 0; l < 3; l++) begin
      case (pix_mode)
        PixRandom:   px[l*PixW +: PixW] = PixW'($urandom);
        PixTwoLevel: px[l*PixW +: PixW] = $urandom_range(0, 1) ? level_hi : level_lo;
        PixFlat:     px[l*PixW +: PixW] = level_flat;
        default:     px[l*PixW +: PixW] = {PixW{$urandom_range(0, 1) == 1}};
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input triple_t px);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    {pix_if.above_pixel, pix_if.mid_pixel, pix_if.below_pixel} <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    n_requests++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // requests that complete no center may still be in flight: settle after the drain
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                           input int unsigned n_items, input bit hold, input bit pause,
                           input bit quiet);
    wait_idle();
    write_reg(CfgFrameWidth, w);
    write_reg(CfgFrameHeight, h);
    n_settings++;
    tx_gaps   = !quiet;
    rx_stalls = !quiet;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 8 == 0) begin
        pix_mode   = pix_mode_e'($urandom_range(0, 3));
        level_lo   = PixW'($urandom);
        level_hi   = level_lo + 1'b1;
        level_flat = PixW'($urandom);
      end
      if (hold && k == 2) hold_off_req = 1'b1;
      if (pause && k == n_items / 2) wait_idle();
      send_pixel(make_pixel());
    end
  endtask

  // result side
  initial begin
    res_if.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgFrameWidth;
    cfg_wdata_i        = '0;
    pix_if.valid       = 1'b0;
    pix_if.below_pixel = '0;
    pix_if.mid_pixel   = '0;
    pix_if.above_pixel = '0;
    n_requests         = 0;
    n_settings         = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size 640x480: first row completes no center
    repeat (3) send_pixel(make_pixel());

    // zero sizes act as 1x1: each pixel is judged only against its own lower and upper layer
    wait_idle();
    write_reg(CfgFrameWidth, '0);
    write_reg(CfgFrameHeight, '0);
    n_settings++;
    send_pixel('0);
    send_pixel('1);
    send_pixel({8'h00, 8'hFF, 8'h00});

    // 3x3: strict max at the center, tied minimum in a corner;
    // spare indexes written mid-frame must not restart it
    wait_idle();
    write_reg(CfgFrameWidth, 13'd3);
    write_reg(CfgFrameHeight, 13'd3);
    n_settings++;
    for (int k = 0; k < 9; k++) begin
      if (k == 4) begin
        wait_idle();
        write_reg(CfgSpare2, '1);
        write_reg(CfgSpare3, '0);
      end
      send_pixel({8'h00, (k == 4) ? 8'hFF : 8'(k * 10), 8'h00});
    end
    // start of a flat frame, cut off by the next size write
    repeat (3) send_pixel({3{8'h07}});

    run_phase(13'd4, 13'd3, 12, 0, 0, 0);
    run_phase(13'h1FFF, 13'd1, 8, 0, 0, 0);   // width clamps to its maximum
    run_phase(13'd1024, 13'd1, 4, 0, 0, 0);
    run_phase(13'd3, 13'h1FFF, 8, 0, 0, 0);   // height clamps to its maximum
    run_phase(13'd3, 13'd2, 16, 1, 0, 0);     // long result stall fills the block
    run_phase(13'd6, 13'd4, 14, 0, 1, 0);     // sender drains mid-frame
    run_phase(13'd2, 13'd3, 8, 0, 0, 1);      // back to back, no stalls
    repeat (3) begin
      run_phase(13'($urandom_range(1, 7)), 13'($urandom_range(1, 6)),
                $urandom_range(4, 10), 0, 0, 0);
    end

    wait_idle();
    $display("run: %0d pixel requests over %0d frame sizes, zero and clamped sizes included",
             n_requests, n_settings);
    $display("run: %0d centers judged, %0d extrema, %0d mismatches",
             centers, peaks, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dogx_pkg.sv
src/dogx_if.sv
src/dogx_ram.sv
src/dogx_line_fetch.sv
src/dogx_judge.sv
src/dog_extremum_detector_core.sv
sim/dogx_center_checker.sv
sim/dog_extremum_detector_core_tb.sv
